// ===== hw/rtl/swa_pkg.sv =====
// shared types, codes and helpers for the affine-gap local alignment scorer
// no dependencies
`default_nettype none

package swa_pkg;

    localparam logic [1:0] MODE_TABLE = 2'd0;
    localparam logic [1:0] MODE_REF   = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic CFG_GAP_OPEN   = 1'b0;
    localparam logic CFG_GAP_EXTEND = 1'b1;

    localparam logic signed [17:0] SAT_HI = 18'sd32767;
    localparam logic signed [17:0] SAT_LO = -18'sd32768;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_REF,
        ST_FETCH_SUB,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic calc;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic len_zero;
        logic last_cell;
        logic emit_pending;
        logic out_free;
    } status_t;

    function automatic logic signed [15:0] clip16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > SAT_HI)
            r = 16'sh7fff;
        else if (v < SAT_LO)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic clipped(input logic signed [17:0] v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swa_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module swa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/swa_ctrl.sv =====
// sequencer for the scorer: accepts words, walks the row cell by cell, emits
// depends on swa_pkg
`default_nettype none

module swa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       mode,
    input  wire logic             last,
    input  wire swa_pkg::status_t st,
    output logic                  in_ready,
    output swa_pkg::cmd_t         cmd
);

    swa_pkg::state_t state_reg, state_next;
    logic acc;

    assign acc = in_valid && (state_reg == swa_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= swa_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swa_pkg::ST_IDLE:
            begin
                if (acc && mode == swa_pkg::MODE_QUERY)
                begin
                    if (!st.len_zero)
                        state_next = swa_pkg::ST_FETCH_REF;
                    else if (last)
                        state_next = swa_pkg::ST_EMIT;
                end
            end
            swa_pkg::ST_FETCH_REF: state_next = swa_pkg::ST_FETCH_SUB;
            swa_pkg::ST_FETCH_SUB: state_next = swa_pkg::ST_CALC;
            swa_pkg::ST_CALC:
            begin
                if (!st.last_cell)
                    state_next = swa_pkg::ST_FETCH_REF;
                else if (st.emit_pending)
                    state_next = swa_pkg::ST_EMIT;
                else
                    state_next = swa_pkg::ST_IDLE;
            end
            swa_pkg::ST_EMIT:
            begin
                if (st.out_free)
                    state_next = swa_pkg::ST_IDLE;
            end
            default: state_next = swa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.calc   = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            swa_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            swa_pkg::ST_CALC: cmd.calc = 1'b1;
            swa_pkg::ST_EMIT: cmd.emit = st.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/swa_dp.sv =====
// datapath: table, reference and column memories, cell arithmetic, result register
// depends on swa_pkg and swa_ram
`default_nettype none

module swa_dp #(
    parameter int unsigned REF_MAX  = 256,
    parameter int unsigned ALPHABET = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire swa_pkg::cmd_t     cmd,
    output swa_pkg::status_t       st,
    input  wire logic [1:0]        mode,
    input  wire logic [4:0]        symbol,
    input  wire logic [4:0]        other_symbol,
    input  wire logic signed [7:0] entry_value,
    input  wire logic              start_req,
    input  wire logic              last,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [6:0]        cfg_data,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [14:0]            best_score,
    output logic                   saturated
);

    localparam int unsigned AW = (REF_MAX > 1) ? $clog2(REF_MAX) : 1;
    localparam int unsigned LW = $clog2(REF_MAX + 1);
    localparam int unsigned YW = $clog2(ALPHABET);
    localparam int unsigned TD = ALPHABET * ALPHABET;
    localparam int unsigned TW = $clog2(TD);

    function automatic logic [YW-1:0] sym_mod(input logic [4:0] v);
        logic [6:0] t;
        t = {2'b00, v};
        for (int i = 0; i < 8; i++)
        begin
            if (t >= 7'(ALPHABET))
                t = t - 7'(ALPHABET);
        end
        return t[YW-1:0];
    endfunction

    logic signed [6:0]  gap_open_reg, gap_extend_reg;
    logic [LW-1:0]      len_reg, count_reg;
    logic [AW-1:0]      j_reg;
    logic [YW-1:0]      q_reg;
    logic               last_reg;
    logic signed [15:0] left_reg, diag_reg, row_gap_reg;
    logic [14:0]        best_reg;
    logic               sat_reg;
    logic               out_valid_reg;
    logic [14:0]        out_best_reg;
    logic               out_sat_reg;

    logic               acc_table, acc_ref, acc_query;
    logic [YW-1:0]      sym_r, osym_r;
    logic [YW-1:0]      ref_rdata;
    logic [7:0]         sub_rdata;
    logic [31:0]        col_rdata;
    logic [TW-1:0]      sub_raddr;
    logic signed [7:0]  step;
    logic               col_zero;
    logic signed [15:0] col_score, col_gap;
    logic signed [17:0] rg_a, rg_b, cg_a, cg_b, dg;
    logic signed [15:0] rg_new, cg_new, dg_c, cell_val;
    logic               sat_any;
    logic [LW-1:0]      j_ext;

    assign acc_table = cmd.accept && mode == swa_pkg::MODE_TABLE;
    assign acc_ref   = cmd.accept && mode == swa_pkg::MODE_REF;
    assign acc_query = cmd.accept && mode == swa_pkg::MODE_QUERY;
    assign sym_r     = sym_mod(symbol);
    assign osym_r    = sym_mod(other_symbol);

    swa_ram #(.WIDTH(8), .DEPTH(TD)) u_table (
        .clk   (clk),
        .we    (acc_table),
        .waddr (TW'(TW'(sym_r) * ALPHABET + TW'(osym_r))),
        .wdata (entry_value),
        .raddr (sub_raddr),
        .rdata (sub_rdata)
    );

    swa_ram #(.WIDTH(YW), .DEPTH(REF_MAX)) u_ref (
        .clk   (clk),
        .we    (acc_ref && (start_req || len_reg < LW'(REF_MAX))),
        .waddr (start_req ? AW'(0) : len_reg[AW-1:0]),
        .wdata (sym_r),
        .raddr (j_reg),
        .rdata (ref_rdata)
    );

    // score in the upper half, gap in the lower half
    swa_ram #(.WIDTH(32), .DEPTH(REF_MAX)) u_col (
        .clk   (clk),
        .we    (cmd.calc),
        .waddr (j_reg),
        .wdata ({cell_val, cg_new}),
        .raddr (j_reg),
        .rdata (col_rdata)
    );

    assign sub_raddr = TW'(TW'(q_reg) * ALPHABET + TW'(ref_rdata));

    // cell arithmetic
    assign step      = 8'(gap_open_reg) + 8'(gap_extend_reg);
    assign j_ext     = LW'(j_reg);
    // entries at or past the high-water mark are read as zero, whatever the memory holds
    assign col_zero  = j_ext >= count_reg;
    assign col_score = col_zero ? 16'sd0 : $signed(col_rdata[31:16]);
    assign col_gap   = col_zero ? 16'sd0 : $signed(col_rdata[15:0]);

    assign rg_a   = 18'(left_reg) + 18'(step);
    assign rg_b   = 18'(row_gap_reg) + 18'(gap_extend_reg);
    assign cg_a   = 18'(col_score) + 18'(step);
    assign cg_b   = 18'(col_gap) + 18'(gap_extend_reg);
    assign dg     = 18'(diag_reg) + 18'($signed(sub_rdata));
    assign rg_new = swa_pkg::clip16((rg_a > rg_b) ? rg_a : rg_b);
    assign cg_new = swa_pkg::clip16((cg_a > cg_b) ? cg_a : cg_b);
    assign dg_c   = swa_pkg::clip16(dg);
    assign sat_any = swa_pkg::clipped((rg_a > rg_b) ? rg_a : rg_b)
                  || swa_pkg::clipped((cg_a > cg_b) ? cg_a : cg_b)
                  || swa_pkg::clipped(dg);

    always_comb
    begin
        cell_val = dg_c;
        if (rg_new > cell_val)
            cell_val = rg_new;
        if (cg_new > cell_val)
            cell_val = cg_new;
        if (cell_val < 16'sd0)
            cell_val = 16'sd0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_open_reg   <= -7'sd10;
            gap_extend_reg <= -7'sd1;
            len_reg        <= '0;
            count_reg      <= '0;
            best_reg       <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == swa_pkg::CFG_GAP_OPEN)
                gap_open_reg <= $signed(cfg_data);
            if (cfg_we && cfg_index == swa_pkg::CFG_GAP_EXTEND)
                gap_extend_reg <= $signed(cfg_data);
            if (acc_ref)
            begin
                if (start_req)
                    len_reg <= LW'(1);
                else if (len_reg < LW'(REF_MAX))
                    len_reg <= len_reg + LW'(1);
            end
            if (acc_query && start_req)
            begin
                count_reg <= '0;
                best_reg  <= '0;
                sat_reg   <= 1'b0;
            end
            if (cmd.calc)
            begin
                if (j_ext >= count_reg)
                    count_reg <= j_ext + LW'(1);
                if (cell_val[14:0] > best_reg)
                    best_reg <= cell_val[14:0];
                if (sat_any)
                    sat_reg <= 1'b1;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // row payload
    always_ff @(posedge clk)
    begin
        if (acc_query)
        begin
            q_reg       <= sym_r;
            last_reg    <= last;
            j_reg       <= '0;
            left_reg    <= '0;
            diag_reg    <= '0;
            row_gap_reg <= 16'(gap_open_reg);
        end
        else if (cmd.calc)
        begin
            j_reg       <= j_reg + AW'(1);
            left_reg    <= cell_val;
            diag_reg    <= col_score;
            row_gap_reg <= rg_new;
        end
        if (cmd.emit)
        begin
            out_best_reg <= best_reg;
            out_sat_reg  <= sat_reg;
        end
    end

    assign st.len_zero     = len_reg == '0;
    assign st.last_cell    = (j_ext + LW'(1)) == len_reg;
    assign st.emit_pending = last_reg;
    assign st.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign best_score = out_best_reg;
    assign saturated  = out_sat_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.out_free)
        else $error("result loaded while the output word is still held");

    a_calc_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc |-> (j_ext < len_reg))
        else $error("cell update beyond the stored reference");

    a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        acc_query && start_req |=> best_reg == '0 && !sat_reg && count_reg == '0)
        else $error("query start did not clear the running state");

endmodule

`default_nettype wire

// ===== hw/rtl/smith_waterman_affine_score.sv =====
// local alignment scorer with affine gaps; table and reference words are stored
// when taken; a query word walks the reference, per position a ref read, table read
// and cell update, then loads the result when last is set, waiting while the output
// word is still held; one query word is worked on at a time; reset clears lengths,
// best score and flags and sets gap open to -10, gap extend to -1, at once; the table
// and reference hold nothing until written; column scores are cleared by a fill count
`default_nettype none

module smith_waterman_affine_score #(
    parameter int unsigned REF_MAX  = 256,
    parameter int unsigned ALPHABET = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        mode,
    input  wire logic [4:0]        symbol,
    input  wire logic [4:0]        other_symbol,
    input  wire logic signed [7:0] entry_value,
    input  wire logic              start_req,
    input  wire logic              last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [14:0]            best_score,
    output logic                   saturated,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [6:0]        cfg_data
);

    swa_pkg::cmd_t    cmd;
    swa_pkg::status_t st;

    swa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .last     (last),
        .st       (st),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    swa_dp #(.REF_MAX(REF_MAX), .ALPHABET(ALPHABET)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .mode         (mode),
        .symbol       (symbol),
        .other_symbol (other_symbol),
        .entry_value  (entry_value),
        .start_req    (start_req),
        .last         (last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .best_score   (best_score),
        .saturated    (saturated)
    );

endmodule

`default_nettype wire

// ===== tb/sv/smith_waterman_affine_score_checker.sv =====
// scoreboard for the affine-gap local alignment scorer: watches the input, output and
// register ports, keeps its own copy of table, reference and column state, compares results
// depends on swa_pkg for mode and register codes
`default_nettype none

module smith_waterman_affine_score_checker #(
    parameter int unsigned REF_MAX  = 256,
    parameter int unsigned ALPHABET = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [1:0]        mode,
    input  wire logic [4:0]        symbol,
    input  wire logic [4:0]        other_symbol,
    input  wire logic signed [7:0] entry_value,
    input  wire logic              start_req,
    input  wire logic              last,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic [14:0]       best_score,
    input  wire logic              saturated,
    input  wire logic              cfg_we,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [6:0]        cfg_data,
    output int                     errors,
    output int                     scores_pending
);

    typedef struct {
        logic [14:0] score;
        logic        sat;
    } score_word_t;

    int          subst [ALPHABET*ALPHABET];
    int          ref_sym [REF_MAX];
    int          ref_len;
    int          col_score [REF_MAX];
    int          col_gap [REF_MAX];
    int          best;
    bit          sat_seen;
    int          open_pen;
    int          ext_pen;
    score_word_t expected_scores[$];

    function automatic int lim16(int v);
        if (v > 32767)
        begin
            sat_seen = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            sat_seen = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic int max2(int a, int b);
        return (a > b) ? a : b;
    endfunction

    task automatic score_row(int q);
        int diag;
        int left;
        int row_gap;
        int step;
        int cell_val;
        diag = 0;
        left = 0;
        row_gap = open_pen;
        step = open_pen + ext_pen;
        for (int j = 0; j < ref_len; j++)
        begin
            row_gap = lim16(max2(left + step, row_gap + ext_pen));
            col_gap[j] = lim16(max2(col_score[j] + step, col_gap[j] + ext_pen));
            cell_val = lim16(diag + subst[q*ALPHABET + ref_sym[j]]);
            cell_val = max2(max2(cell_val, row_gap), max2(col_gap[j], 0));
            diag = col_score[j];
            col_score[j] = cell_val;
            left = cell_val;
            best = max2(best, cell_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        score_word_t w;
        if (!rst_n)
        begin
            foreach (subst[i]) subst[i] = 0;
            foreach (ref_sym[i]) ref_sym[i] = 0;
            foreach (col_score[i]) col_score[i] = 0;
            foreach (col_gap[i]) col_gap[i] = 0;
            ref_len = 0;
            best = 0;
            sat_seen = 1'b0;
            open_pen = -10;
            ext_pen = -1;
            errors = 0;
            expected_scores.delete();
            scores_pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == swa_pkg::CFG_GAP_OPEN)
                    open_pen = int'($signed(cfg_data));
                else
                    ext_pen = int'($signed(cfg_data));
            end
            if (out_valid && out_ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected score word: score %0d sat %0b",
                                 best_score, saturated);
                end
                else
                begin
                    w = expected_scores.pop_front();
                    if (w.score !== best_score || w.sat !== saturated)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("score mismatch: expected %0d/%0b got %0d/%0b",
                                     w.score, w.sat, best_score, saturated);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (mode)
                    swa_pkg::MODE_TABLE:
                        subst[(symbol % ALPHABET)*ALPHABET + (other_symbol % ALPHABET)] =
                            int'(entry_value);
                    swa_pkg::MODE_REF:
                    begin
                        if (start_req)
                            ref_len = 0;
                        if (ref_len < REF_MAX)
                        begin
                            ref_sym[ref_len] = symbol % ALPHABET;
                            ref_len++;
                        end
                    end
                    swa_pkg::MODE_QUERY:
                    begin
                        if (start_req)
                        begin
                            foreach (col_score[i]) col_score[i] = 0;
                            foreach (col_gap[i]) col_gap[i] = 0;
                            best = 0;
                            sat_seen = 1'b0;
                        end
                        score_row(symbol % ALPHABET);
                        if (last)
                        begin
                            w.score = best[14:0];
                            w.sat = sat_seen;
                            expected_scores.push_back(w);
                        end
                    end
                    default: ;
                endcase
            end
            scores_pending = expected_scores.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/smith_waterman_affine_score_test.sv =====
// top of the alignment scorer testbench: clock, reset, stimulus and verdict
// depends on swa_pkg, smith_waterman_affine_score and smith_waterman_affine_score_checker
`default_nettype none

module smith_waterman_affine_score_test;

    localparam int REF_MAX = 256;
    localparam int STALL_LIMIT = 40000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        mode;
    logic [4:0]        symbol;
    logic [4:0]        other_symbol;
    logic signed [7:0] entry_value;
    logic              start_req;
    logic              last;
    logic              out_valid;
    logic              out_ready;
    logic [14:0]       best_score;
    logic              saturated;
    logic              cfg_we;
    logic [0:0]        cfg_index;
    logic [6:0]        cfg_data;
    int                errors;
    int                scores_pending;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                max_ref_len;
    int                stall_cycles;

    smith_waterman_affine_score dut (.*);

    smith_waterman_affine_score_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("smith_waterman_affine_score regression: fail");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge after the word is taken
    // ready depends on the sequencer state only, so it is settled at the falling edge
    task automatic send_word(logic [1:0] m, logic [4:0] s, logic [4:0] os,
                             logic [7:0] v, logic st, logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        mode = m;
        symbol = s;
        other_symbol = os;
        entry_value = v;
        start_req = st;
        last = lst;
        in_valid = 1'b1;
        while (!in_ready)
            @(negedge clk);
        @(negedge clk);
        if (m == swa_pkg::MODE_REF)
            max_ref_len = (max_ref_len < REF_MAX) ? max_ref_len + 1 : REF_MAX;
    endtask

    // wait until the block is idle so the gap registers can change
    task automatic settle();
        in_valid = 1'b0;
        while (scores_pending != 0)
            @(negedge clk);
        repeat (3*max_ref_len + 10) @(negedge clk);
    endtask

    task automatic set_gaps(logic [6:0] open_v, logic [6:0] ext_v);
        settle();
        cfg_we = 1'b1;
        cfg_index = swa_pkg::CFG_GAP_OPEN;
        cfg_data = open_v;
        @(negedge clk);
        cfg_index = swa_pkg::CFG_GAP_EXTEND;
        cfg_data = ext_v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_reference(int n);
        for (int i = 0; i < n; i++)
            send_word(swa_pkg::MODE_REF, 5'($urandom_range(0, 31)), 5'($urandom),
                      8'($urandom), i == 0, $urandom_range(0, 9) == 0);
    endtask

    task automatic run_query(int n);
        for (int i = 0; i < n; i++)
            send_word(swa_pkg::MODE_QUERY, 5'($urandom_range(0, 31)), 5'($urandom),
                      8'($urandom), i == 0, i == n - 1);
    endtask

    initial
    begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = swa_pkg::MODE_TABLE;
        symbol = '0;
        other_symbol = '0;
        entry_value = '0;
        start_req = 1'b0;
        last = 1'b0;
        cfg_we = 1'b0;
        cfg_index = swa_pkg::CFG_GAP_OPEN;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        max_ref_len = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty reference: a query still gives a score word
        send_word(swa_pkg::MODE_QUERY, 5'd31, 5'd0, 8'd0, 1'b1, 1'b1);
        // fill the whole table so no unwritten entry is ever read
        for (int q = 0; q < 32; q++)
            for (int r = 0; r < 32; r++)
                send_word(swa_pkg::MODE_TABLE, 5'(q), 5'(r),
                          (q == r) ? 8'($urandom_range(1, 127)) : 8'($urandom), 1'b0, 1'b0);
        send_word(swa_pkg::MODE_TABLE, 5'd31, 5'd31, 8'sd127, 1'b0, 1'b1);
        send_word(swa_pkg::MODE_TABLE, 5'd0, 5'd0, -8'sd128, 1'b0, 1'b0);
        send_word(swa_pkg::MODE_SPARE, 5'd31, 5'd31, 8'hff, 1'b1, 1'b1);
        send_word(swa_pkg::MODE_REF, 5'd31, 5'd0, 8'd0, 1'b1, 1'b1);
        send_word(swa_pkg::MODE_REF, 5'd0, 5'd31, 8'd0, 1'b0, 1'b0);
        send_word(swa_pkg::MODE_QUERY, 5'd31, 5'd0, 8'd0, 1'b0, 1'b0);
        send_word(swa_pkg::MODE_QUERY, 5'd0, 5'd0, 8'd0, 1'b0, 1'b1);
        run_query(4);
        set_gaps(7'h40, 7'h40);
        load_reference(6);
        run_query(5);
        set_gaps(7'h00, 7'h00);
        run_query(5);
        // reference past full: the extra symbols are dropped
        load_reference(REF_MAX + 4);
        run_query(3);
        // positive gap values let column gaps grow until they clip
        set_gaps(7'd63, 7'd63);
        load_reference(200);
        run_query(80);
        set_gaps(7'h76, 7'h7f);
        load_reference(3);
        max_ref_len = 3;

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 26 : 0;
            n = 0;
            while (n < 140)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: set_gaps(7'h40, 7'($urandom));
                        1: set_gaps(7'($urandom), 7'h00);
                        default: set_gaps(7'(-$urandom_range(0, 64)),
                                          7'(-$urandom_range(0, 64)));
                    endcase
                    max_ref_len = 0;
                end
                if ($urandom_range(0, 3) == 0)
                    for (int i = $urandom_range(1, 4); i > 0; i--)
                    begin
                        send_word(swa_pkg::MODE_TABLE, 5'($urandom), 5'($urandom),
                                  8'($urandom), 1'($urandom), 1'($urandom));
                        n++;
                    end
                if ($urandom_range(0, 2) != 0)
                begin
                    int len;
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64)
                                                       : $urandom_range(1, 12);
                    load_reference(len);
                    n += len;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    // noise: stray query rows, ignored mode, loose flags
                    send_word($urandom_range(0, 1) ? swa_pkg::MODE_SPARE : swa_pkg::MODE_QUERY,
                              5'($urandom), 5'($urandom), 8'($urandom), 1'($urandom),
                              1'($urandom));
                    n++;
                end
                begin
                    int qlen;
                    qlen = $urandom_range(1, 8);
                    run_query(qlen);
                    n += qlen;
                end
            end
        end

        in_valid = 1'b0;
        while (scores_pending != 0)
            @(negedge clk);
        repeat (3*REF_MAX + 10) @(negedge clk);
        if (errors == 0)
            $display("smith_waterman_affine_score regression: pass");
        else
            $display("smith_waterman_affine_score regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
